// ===== src/assert_macros.svh =====
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and codes shared by the first-fit pool allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    localparam int SIZE_W = 16;
    localparam int SUM_W  = 18;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE   = 2'd1;
    localparam logic [1:0] ST_NO_FIT     = 2'd2;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

`default_nettype wire

// ===== src/ffpa_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_hdr_ram
// Header store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_hdr_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic           i_clk,
    input  wire logic           i_wr_en,
    input  wire logic [AW-1:0]  i_wr_addr,
    input  wire ffpa_pkg::t_hdr i_wr_data,
    input  wire logic           i_rd_en,
    input  wire logic [AW-1:0]  i_rd_addr,
    output ffpa_pkg::t_hdr      o_rd_data
);
    import ffpa_pkg::*;

    t_hdr r_mem [DEPTH];
    t_hdr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/first_fit_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit allocator over a byte pool of header-prefixed blocks, with
// coalescing of adjacent free blocks on every successful free.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_action, i_req_size, i_release_offset
// result    out        o_out_valid / i_out_ready  o_status, o_payload_offset
//
// An allocate reads the header of each block visited by the walk, then writes
// one or two headers; a bad size is answered from idle without a walk.
// A free walks the blocks up to the target, then does a full coalescing walk
// block by block and merge by merge; the header memory read port sets this pace.
// After reset the S_INIT state writes the initial header before the first item.
// A stalled result holds the block: the next item is taken once it is gone.
`default_nettype none

module first_fit_pool_allocator #(
    parameter int POOL_BYTES   = 32768,
    parameter int HEADER_BYTES = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [15:0] i_req_size,
    input  wire logic [14:0] i_release_offset,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [14:0]      o_payload_offset
);
    import ffpa_pkg::*;

    localparam int AW = $clog2(POOL_BYTES);
    localparam logic [SUM_W-1:0] HB   = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] POOL = SUM_W'(POOL_BYTES);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_AWALK  = 3'd2;
    localparam logic [2:0] S_AWR2   = 3'd3;
    localparam logic [2:0] S_FWALK  = 3'd4;
    localparam logic [2:0] S_CSTART = 3'd5;
    localparam logic [2:0] S_CWALK  = 3'd6;
    localparam logic [2:0] S_CNEXT  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_h, n_h;
    logic [AW-1:0]     r_nx, n_nx;
    logic [SIZE_W-1:0] r_req, n_req;
    logic [SIZE_W-1:0] r_cur, n_cur;
    logic [SUM_W-1:0]  r_tgt, n_tgt;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_status, n_status;
    logic [14:0]       r_poff, n_poff;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_hdr          wr_data, rd_data;

    logic [SUM_W-1:0]  h_ext, nx_cur, nx_after, nx_merged;
    logic [SIZE_W-1:0] merged;

    ffpa_hdr_ram #(.DEPTH(POOL_BYTES), .AW(AW)) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        h_ext     = SUM_W'(r_h);
        nx_cur    = h_ext + HB + SUM_W'(rd_data.size);
        nx_after  = SUM_W'(r_nx) + HB + SUM_W'(rd_data.size);
        merged    = SIZE_W'(SUM_W'(r_cur) + HB + SUM_W'(rd_data.size));
        nx_merged = h_ext + HB + SUM_W'(merged);

        n_state  = r_state;
        n_h      = r_h;
        n_nx     = r_nx;
        n_req    = r_req;
        n_cur    = r_cur;
        n_tgt    = r_tgt;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_poff   = r_poff;
        wr_en    = 1'b0;
        wr_addr  = r_h;
        wr_data  = '{free: 1'b0, size: r_req};
        rd_en    = 1'b0;
        rd_addr  = '0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{free: 1'b1, size: SIZE_W'(POOL - HB)};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_h     = '0;
                    n_req   = i_req_size;
                    n_tgt   = SUM_W'(i_release_offset) - HB;
                    n_poff  = '0;
                    if (i_action == ACT_ALLOC) begin
                        if (i_req_size == '0 || SUM_W'(i_req_size) > POOL) begin
                            n_ovalid = 1'b1;
                            n_status = ST_BAD_SIZE;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_AWALK;
                        end
                    end else begin
                        if (SUM_W'(i_release_offset) < HB) begin
                            n_ovalid = 1'b1;
                            n_status = ST_BAD_OFFSET;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_FWALK;
                        end
                    end
                end
            end
            S_AWALK: begin
                if (rd_data.free && rd_data.size >= r_req) begin
                    if (SUM_W'(rd_data.size) >= SUM_W'(r_req) + HB) begin
                        // Split: the rest becomes a new free block behind the grant.
                        wr_en   = 1'b1;
                        wr_addr = AW'(h_ext + HB + SUM_W'(r_req));
                        wr_data = '{free: 1'b1,
                                    size: SIZE_W'(SUM_W'(rd_data.size) - SUM_W'(r_req) - HB)};
                        n_state = S_AWR2;
                    end else begin
                        wr_en    = 1'b1;
                        wr_data  = '{free: 1'b0, size: rd_data.size};
                        n_ovalid = 1'b1;
                        n_status = ST_OK;
                        n_poff   = 15'(h_ext + HB);
                        n_state  = S_IDLE;
                    end
                end else if (nx_cur >= POOL) begin
                    n_ovalid = 1'b1;
                    n_status = ST_NO_FIT;
                    n_state  = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(nx_cur);
                    n_h     = AW'(nx_cur);
                end
            end
            S_AWR2: begin
                wr_en    = 1'b1;
                wr_data  = '{free: 1'b0, size: r_req};
                n_ovalid = 1'b1;
                n_status = ST_OK;
                n_poff   = 15'(h_ext + HB);
                n_state  = S_IDLE;
            end
            S_FWALK: begin
                if (h_ext == r_tgt) begin
                    if (rd_data.free) begin
                        n_ovalid = 1'b1;
                        n_status = ST_BAD_OFFSET;
                        n_state  = S_IDLE;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = '{free: 1'b1, size: rd_data.size};
                        n_state = S_CSTART;
                    end
                end else if (nx_cur > r_tgt || nx_cur >= POOL) begin
                    n_ovalid = 1'b1;
                    n_status = ST_BAD_OFFSET;
                    n_state  = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(nx_cur);
                    n_h     = AW'(nx_cur);
                end
            end
            S_CSTART: begin
                rd_en   = 1'b1;
                n_h     = '0;
                n_state = S_CWALK;
            end
            S_CWALK: begin
                if (nx_cur >= POOL) begin
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else if (rd_data.free) begin
                    // Look at the neighbor while keeping this block as the merge base.
                    rd_en   = 1'b1;
                    rd_addr = AW'(nx_cur);
                    n_nx    = AW'(nx_cur);
                    n_cur   = rd_data.size;
                    n_state = S_CNEXT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(nx_cur);
                    n_h     = AW'(nx_cur);
                end
            end
            S_CNEXT: begin
                if (rd_data.free) begin
                    wr_en   = 1'b1;
                    wr_data = '{free: 1'b1, size: merged};
                    n_cur   = merged;
                    if (nx_merged >= POOL) begin
                        n_ovalid = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(nx_merged);
                        n_nx    = AW'(nx_merged);
                    end
                end else if (nx_after >= POOL) begin
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    // The neighbor is in use, so the walk resumes behind it.
                    rd_en   = 1'b1;
                    rd_addr = AW'(nx_after);
                    n_h     = AW'(nx_after);
                    n_state = S_CWALK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_h      <= n_h;
        r_nx     <= n_nx;
        r_req    <= n_req;
        r_cur    <= n_cur;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_poff   <= n_poff;
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_status;
    assign o_payload_offset = r_poff;

`include "assert_macros.svh"

    `ASSERT_SAME(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE && !r_ovalid)
    `ASSERT_SAME(a_offset_only_ok, i_clk, i_rst_n, r_ovalid && r_status != ST_OK, r_poff == '0)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_SAME(a_no_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !wr_en)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks first_fit_pool_allocator against a predictor of the pool that keeps
// its own copy of the block headers and start markers. The stimulus is a short
// directed part, then random allocate/free traffic, with random idling and
// stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

import ffpa_pkg::*;

typedef struct {
    logic [1:0]  status;
    logic [14:0] offset;
} t_grant;

class pool_tracker;
    localparam int POOL = 32768;
    localparam int HDR  = 24;

    bit [16:0] hdr_mem[POOL];
    bit        start_map[POOL];
    t_grant    pending[$];
    int        mismatches;
    int        results_seen;

    function new();
        hdr_mem[0]   = {1'b1, 16'(POOL - HDR)};
        start_map[0] = 1'b1;
    endfunction

    function int next_block(int h);
        return h + HDR + int'(hdr_mem[h][15:0]);
    endfunction

    function void merge_free_runs();
        int h;
        int nx;
        h = 0;
        while (h < POOL) begin
            nx = next_block(h);
            if (hdr_mem[h][16] && nx < POOL && hdr_mem[nx][16]) begin
                hdr_mem[h] = {1'b1, 16'(int'(hdr_mem[h][15:0]) + HDR
                                         + int'(hdr_mem[nx][15:0]))};
                start_map[nx] = 1'b0;
            end else begin
                h = nx;
            end
        end
    endfunction

    // Computes the answer to an accepted request and queues it.
    function t_grant take_request(logic act, logic [15:0] size, logic [14:0] off);
        t_grant g;
        int h;
        int sz;
        int req;
        g.status = ST_OK;
        g.offset = '0;
        req = int'(size);
        if (act == ACT_ALLOC) begin
            if (req == 0 || req > POOL) begin
                g.status = ST_BAD_SIZE;
            end else begin
                g.status = ST_NO_FIT;
                h = 0;
                while (h < POOL) begin
                    sz = int'(hdr_mem[h][15:0]);
                    if (hdr_mem[h][16] && sz >= req) begin
                        if (sz >= req + HDR) begin
                            hdr_mem[h + HDR + req]   = {1'b1, 16'(sz - req - HDR)};
                            start_map[h + HDR + req] = 1'b1;
                            sz = req;
                        end
                        hdr_mem[h] = {1'b0, 16'(sz)};
                        g.status = ST_OK;
                        g.offset = 15'(h + HDR);
                        break;
                    end
                    h = next_block(h);
                end
            end
        end else begin
            h = int'(off) - HDR;
            if (int'(off) < HDR || h >= POOL || !start_map[h] || hdr_mem[h][16]) begin
                g.status = ST_BAD_OFFSET;
            end else begin
                hdr_mem[h][16] = 1'b1;
                merge_free_runs();
            end
        end
        pending.push_back(g);
        return g;
    endfunction

    function void check_result(logic [1:0] status, logic [14:0] offset);
        t_grant g;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status %0d offset %0d", status, offset);
            return;
        end
        g = pending.pop_front();
        if (status !== g.status || offset !== g.offset) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                         g.status, g.offset, status, offset);
        end
    endfunction
endclass

module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [15:0] i_req_size;
    logic [14:0] i_release_offset;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [14:0] o_payload_offset;

    pool_tracker tracker;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          items_sent;
    int          tail_wait;
    logic [14:0] live_offsets[$];

    first_fit_pool_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_req_size       (i_req_size),
        .i_release_offset (i_release_offset),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_out_valid && i_out_ready)
                tracker.check_result(o_status, o_payload_offset);
        end
    end

    // Presents one item and returns at the edge where it is accepted.
    task automatic send_item(logic act, logic [15:0] size, logic [14:0] off);
        t_grant g;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_req_size       <= size;
        i_release_offset <= off;
        do @(posedge i_clk); while (!o_in_ready);
        g = tracker.take_request(act, size, off);
        items_sent++;
        if (act == ACT_ALLOC && g.status == ST_OK)
            live_offsets.push_back(g.offset);
        if (act == ACT_FREE && g.status == ST_OK)
            foreach (live_offsets[k])
                if (live_offsets[k] == off) begin
                    live_offsets.delete(k);
                    break;
                end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 4) begin
            send_item(ACT_ALLOC, ($urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 32769))),
                      15'($urandom));
        end else if (pick < 10) begin
            send_item(ACT_FREE, 16'($urandom), 15'($urandom));
        end else if (pick < 14 && live_offsets.size() > 0) begin
            // Off-by-some offsets near a live block exercise the non-start check.
            k = $urandom_range(live_offsets.size() - 1);
            send_item(ACT_FREE, 16'($urandom),
                      live_offsets[k] + 15'($urandom_range(30, 1)));
        end else if ((pick < 55 || live_offsets.size() > 40) && live_offsets.size() > 0) begin
            k = $urandom_range(live_offsets.size() - 1);
            send_item(ACT_FREE, 16'($urandom), live_offsets[k]);
        end else if (pick < 94) begin
            send_item(ACT_ALLOC, 16'($urandom_range(512, 1)), 15'($urandom));
        end else if (pick < 98) begin
            send_item(ACT_ALLOC, 16'($urandom_range(8000, 513)), 15'($urandom));
        end else begin
            send_item(ACT_ALLOC, 16'($urandom_range(32768, 16000)), 15'($urandom));
        end
    endtask

    initial begin
        tracker          = new();
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_action         = ACT_ALLOC;
        i_req_size       = '0;
        i_release_offset = '0;
        i_out_ready      = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        items_sent       = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(ACT_ALLOC, 16'd0, 15'd0);
        send_item(ACT_ALLOC, 16'd32768, 15'd0);
        send_item(ACT_ALLOC, 16'hFFFF, 15'h7FFF);
        send_item(ACT_FREE, 16'd0, 15'd0);
        send_item(ACT_FREE, 16'hFFFF, 15'd23);
        send_item(ACT_FREE, 16'd0, 15'h7FFF);
        send_item(ACT_ALLOC, 16'd32744, 15'd0);
        send_item(ACT_ALLOC, 16'd1, 15'd0);
        send_item(ACT_FREE, 16'd0, 15'd24);
        // The remainder is exactly one header, leaving a zero-size free block.
        send_item(ACT_ALLOC, 16'd32720, 15'd0);
        send_item(ACT_ALLOC, 16'd1, 15'd0);
        send_item(ACT_FREE, 16'd0, 15'd24);
        send_item(ACT_ALLOC, 16'd100, 15'd0);
        send_item(ACT_ALLOC, 16'd200, 15'd0);
        send_item(ACT_FREE, 16'd0, 15'd25);
        send_item(ACT_FREE, 16'd0, 15'd24);
        send_item(ACT_FREE, 16'd0, 15'd24);
        send_item(ACT_ALLOC, 16'd50, 15'd0);
        send_item(ACT_FREE, 16'd0, 15'd148);
        send_item(ACT_FREE, 16'd0, 15'd24);
        live_offsets.delete();
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 38 : (phase == 1) ? 85 : 0;
            recv_stall_pct = (phase == 0) ? 85 : (phase == 1) ? 38 : 0;
            for (int n = 0; n < 260; n++) begin
                random_item();
                if (n == 130)
                    drain_results();
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        tail_wait = 2000;
        repeat (tail_wait) @(posedge i_clk);
        $display("Sent %0d items (directed edge cases, then random allocate/free traffic),",
                 items_sent);
        $display("checked %0d results under three idle and stall mixes.", tracker.results_seen);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", tracker.mismatches,
                     tracker.pending.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
